// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Antecedent in this cycle, consequent required in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/mrrs_pkg.sv -----
// Types and constants of the mailbox round-trip retry sequencer.
package mrrs_pkg;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_SPACE   = 4'b0010,
    PH_DRAIN   = 4'b0100,
    PH_BACKOFF = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    OC_OK      = 3'd0,
    OC_EMPTY   = 3'd1,
    OC_WRFULL  = 3'd2,
    OC_RACED   = 3'd3,
    OC_BADRESP = 3'd4
  } outcome_e;

  typedef enum logic [1:0] {
    CFG_BUFFER_ADDRESS = 2'd0,
    CFG_SPIN_LIMIT     = 2'd1,
    CFG_RETRY_LIMIT    = 2'd2,
    CFG_RETRY_DELAY    = 2'd3
  } cfg_idx_e;

  localparam logic OP_START = 1'b0;
  localparam logic OP_POLL  = 1'b1;

  localparam logic [31:0] RESP_OK   = 32'h8000_0000;
  localparam logic [31:0] CHAN_MASK = ~32'hF;
  localparam logic [31:0] CHAN_NUM  = 32'd8;

  localparam logic [31:0] SPIN_LIMIT_RST  = 32'd4000000;
  localparam logic [7:0]  RETRY_LIMIT_RST = 8'd8;
  localparam logic [15:0] RETRY_DELAY_RST = 16'd2000;

  typedef struct packed {
    logic [31:0] buffer_address;
    logic [31:0] spin_limit;
    logic [7:0]  retry_limit;
    logic [15:0] retry_delay;
  } cfg_t;

  typedef struct packed {
    logic        post_strobe;
    logic [31:0] post_word;
    logic        pop_strobe;
    logic        finished;
    outcome_e    outcome;
    logic [31:0] foreign_word;
    logic        busy_res;
  } result_t;

endpackage

// ----- hw/rtl/mrrs_if.sv -----
// Valid/ready channel interfaces for poll items and result items.
interface mrrs_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic        write_full;
  logic        read_empty;
  logic [31:0] head_word;
  logic [31:0] response_code;

  modport source (output valid, opcode, write_full, read_empty, head_word, response_code,
                  input ready);
  modport sink (input valid, opcode, write_full, read_empty, head_word, response_code,
                output ready);
endinterface

interface mrrs_out_if;
  logic        valid;
  logic        ready;
  logic        post_strobe;
  logic [31:0] post_word;
  logic        pop_strobe;
  logic        finished;
  logic [2:0]  outcome;
  logic [31:0] foreign_word;
  logic        busy_res;

  modport source (output valid, post_strobe, post_word, pop_strobe, finished, outcome,
                  foreign_word, busy_res, input ready);
  modport sink (input valid, post_strobe, post_word, pop_strobe, finished, outcome,
                foreign_word, busy_res, output ready);
endinterface

// ----- hw/rtl/mrrs_cfg_regs.sv -----
// Configuration register file written through the plain write port.
module mrrs_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  output mrrs_pkg::cfg_t     cfg_o
);
  import mrrs_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BUFFER_ADDRESS: cfg_d.buffer_address = cfg_wdata_i;
        CFG_SPIN_LIMIT:     cfg_d.spin_limit     = cfg_wdata_i;
        CFG_RETRY_LIMIT:    cfg_d.retry_limit    = cfg_wdata_i[7:0];
        CFG_RETRY_DELAY:    cfg_d.retry_delay    = cfg_wdata_i[15:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.buffer_address <= '0;
      cfg_q.spin_limit     <= SPIN_LIMIT_RST;
      cfg_q.retry_limit    <= RETRY_LIMIT_RST;
      cfg_q.retry_delay    <= RETRY_DELAY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

// ----- hw/rtl/mrrs_seq_core.sv -----
// Transaction state machine: computes the result of one item and updates state on accept.
module mrrs_seq_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mrrs_pkg::cfg_t    cfg_i,
  input  logic              accept_i,
  input  logic              opcode_i,
  input  logic              write_full_i,
  input  logic              read_empty_i,
  input  logic [31:0]       head_word_i,
  input  logic [31:0]       response_code_i,
  output mrrs_pkg::result_t result_o
);
  import mrrs_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] spin_q, spin_d;
  logic [7:0]  attempt_q, attempt_d;
  logic [15:0] backoff_q, backoff_d;
  logic        saw_q, saw_d;
  logic [31:0] raced_q, raced_d;

  logic        poll;
  logic [31:0] req_word;
  logic        end_req;
  outcome_e    end_oc;
  logic        begin_req;
  logic        matched;
  logic [31:0] spin_dec;
  logic [15:0] backoff_dec;
  logic [7:0]  lim;
  logic [7:0]  attempt_inc;

  assign poll     = (opcode_i == OP_POLL);
  assign req_word = (cfg_i.buffer_address & CHAN_MASK) | CHAN_NUM;
  assign lim      = (cfg_i.retry_limit == 8'd0) ? 8'd1 : cfg_i.retry_limit;
  assign spin_dec = spin_q - 32'd1;
  assign backoff_dec = (backoff_q != 16'd0) ? backoff_q - 16'd1 : 16'd0;
  assign matched  = !read_empty_i && (head_word_i == req_word);

  always_comb begin
    phase_d     = phase_q;
    spin_d      = spin_q;
    attempt_d   = attempt_q;
    backoff_d   = backoff_q;
    saw_d       = saw_q;
    raced_d     = raced_q;
    end_req     = 1'b0;
    end_oc      = OC_OK;
    begin_req   = 1'b0;
    attempt_inc = attempt_q;
    result_o    = '0;

    unique case (phase_q)
      PH_SPACE: begin
        if (poll) begin
          if (!write_full_i) begin
            result_o.post_strobe = 1'b1;
            result_o.post_word   = req_word;
            phase_d = PH_DRAIN;
            spin_d  = cfg_i.spin_limit;
            if (cfg_i.spin_limit == 32'd0) begin
              end_req = 1'b1;
              end_oc  = OC_EMPTY;
            end
          end else if (spin_q == 32'd0) begin
            end_req = 1'b1;
            end_oc  = OC_WRFULL;
          end else begin
            spin_d = spin_dec;
          end
        end
      end
      PH_DRAIN: begin
        if (poll) begin
          if (spin_q == 32'd0) begin
            end_req = 1'b1;
            end_oc  = saw_q ? OC_RACED : OC_EMPTY;
          end else begin
            if (!read_empty_i) begin
              result_o.pop_strobe = 1'b1;
              saw_d = 1'b1;
              if (!matched) raced_d = head_word_i;
            end
            if (matched) begin
              end_req = 1'b1;
              end_oc  = (response_code_i == RESP_OK) ? OC_OK : OC_BADRESP;
            end else begin
              spin_d = spin_dec;
              if (spin_dec == 32'd0) begin
                end_req = 1'b1;
                end_oc  = saw_d ? OC_RACED : OC_EMPTY;
              end
            end
          end
        end
      end
      PH_BACKOFF: begin
        if (poll) begin
          backoff_d = backoff_dec;
          if (backoff_dec == 16'd0) begin_req = 1'b1;
        end
      end
      default: begin
        // Idle: a start item opens a new transaction, a poll does nothing.
        if (!poll) begin
          attempt_d = 8'd0;
          backoff_d = 16'd0;
          begin_req = 1'b1;
        end
      end
    endcase

    if (end_req) begin
      // A successful attempt counts with wrap; a failed one saturates.
      if (end_oc == OC_OK || attempt_q != 8'hFF) begin
        attempt_inc = attempt_q + 8'd1;
      end
      attempt_d = attempt_inc;
      if (end_oc == OC_OK || attempt_inc >= lim) begin
        result_o.finished     = 1'b1;
        result_o.outcome      = end_oc;
        result_o.foreign_word = raced_d;
        phase_d = PH_IDLE;
      end else if (cfg_i.retry_delay == 16'd0) begin
        begin_req = 1'b1;
      end else begin
        phase_d   = PH_BACKOFF;
        backoff_d = cfg_i.retry_delay;
      end
    end

    if (begin_req) begin
      phase_d = PH_SPACE;
      spin_d  = cfg_i.spin_limit;
      saw_d   = 1'b0;
      raced_d = 32'd0;
    end

    result_o.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      spin_q    <= '0;
      attempt_q <= '0;
      backoff_q <= '0;
      saw_q     <= 1'b0;
      raced_q   <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      spin_q    <= spin_d;
      attempt_q <= attempt_d;
      backoff_q <= backoff_d;
      saw_q     <= saw_d;
      raced_q   <= raced_d;
    end
  end
endmodule

// ----- hw/rtl/mrrs_out_reg.sv -----
// Result register that holds one result item until the consumer takes it.
module mrrs_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mrrs_pkg::result_t result_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              in_ready_o,
  output mrrs_pkg::result_t result_o
);
  import mrrs_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  // The slot frees up in the same cycle that its item is taken.
  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;
endmodule

// ----- hw/rtl/mailbox_roundtrip_retry_sequencer.sv -----
// Top level of the mailbox round-trip retry sequencer.
//
//   channel   | direction | payload
//   ----------+-----------+-----------------------------------------------------------
//   in_chan   | in        | opcode, write_full, read_empty, head_word, response_code
//   out_chan  | out       | post_strobe, post_word, pop_strobe, finished, outcome,
//             |           | foreign_word, busy_res
//   cfg       | in        | cfg_we_i, cfg_index_i, cfg_wdata_i
//
// One item is accepted per cycle while the result register is free or being drained; its result
// appears there in the next cycle. The state update of the sequencer state machine sets the rate.
// Reset is asynchronous and active low; it idles the state machine and loads register defaults.
// A stalled result register holds its item and accepts a new one in the cycle it is taken.
module mailbox_roundtrip_retry_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  mrrs_in_if.sink     in_chan,
  mrrs_out_if.source  out_chan
);
  import mrrs_pkg::*;

  cfg_t    cfg;
  result_t core_res;
  result_t out_res;
  logic    accept;
  logic    in_ready;

  assign accept        = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  mrrs_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mrrs_seq_core u_seq_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .accept_i        (accept),
    .opcode_i        (in_chan.opcode),
    .write_full_i    (in_chan.write_full),
    .read_empty_i    (in_chan.read_empty),
    .head_word_i     (in_chan.head_word),
    .response_code_i (in_chan.response_code),
    .result_o        (core_res)
  );

  mrrs_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .result_i    (core_res),
    .out_ready_i (out_chan.ready),
    .out_valid_o (out_chan.valid),
    .in_ready_o  (in_ready),
    .result_o    (out_res)
  );

  assign out_chan.post_strobe  = out_res.post_strobe;
  assign out_chan.post_word    = out_res.post_word;
  assign out_chan.pop_strobe   = out_res.pop_strobe;
  assign out_chan.finished     = out_res.finished;
  assign out_chan.outcome      = out_res.outcome;
  assign out_chan.foreign_word = out_res.foreign_word;
  assign out_chan.busy_res     = out_res.busy_res;
endmodule

// ----- hw/rtl/mrrs_checker.sv -----
// Port-level assertions for the sequencer and the bind that attaches them.
`include "assert_macros.svh"

module mrrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  mrrs_in_if.sink    in_chan,
  mrrs_out_if.source out_chan
);
  logic in_acc;
  logic out_stall;

  assign in_acc    = in_chan.valid && in_chan.ready;
  assign out_stall = out_chan.valid && !out_chan.ready;

  // A stalled result keeps its place on the channel.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_chan.valid)
  // No item enters while the result register is full and not being drained.
  `ASSERT_ALWAYS(a_no_overrun, clk_i, rst_ni, out_stall |-> !in_chan.ready)
  // Every accepted item yields a result in the next cycle.
  `ASSERT_NEXT(a_result_follows, clk_i, rst_ni, in_acc, out_chan.valid)
  // A finished transaction leaves the sequencer idle, and a post never pops.
  `ASSERT_ALWAYS(a_finish_idle, clk_i, rst_ni,
                 (out_chan.valid && out_chan.finished) |-> !out_chan.busy_res)
  `ASSERT_ALWAYS(a_post_xor_pop, clk_i, rst_ni,
                 out_chan.valid |-> !(out_chan.post_strobe && out_chan.pop_strobe))
endmodule

bind mailbox_roundtrip_retry_sequencer mrrs_checker u_mrrs_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_chan  (in_chan),
  .out_chan (out_chan)
);

// ----- bench/tb_mailbox_roundtrip_retry_sequencer.sv -----
// Self-checking testbench for the mailbox round-trip retry sequencer.
`timescale 1ns / 100ps

module tb_mailbox_roundtrip_retry_sequencer;
  import mrrs_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 32;
  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic        opcode;
    logic        write_full;
    logic        read_empty;
    logic [31:0] head_word;
    logic [31:0] response_code;
  } poll_item_t;

  typedef struct {
    bit         is_cfg;
    cfg_idx_e   idx;
    logic [31:0] data;
    poll_item_t item;
    bit         known;
    result_t    want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_wdata_i;

  mrrs_in_if  in_chan ();
  mrrs_out_if out_chan ();

  mailbox_roundtrip_retry_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

  always #5 clk_i = ~clk_i;

  // Register copies and sequencer state as the block should hold them.
  logic [31:0] m_buf;
  logic [31:0] m_spin;
  logic [7:0]  m_retries;
  logic [15:0] m_delay;
  phase_e      m_phase;
  logic [31:0] m_spin_cnt;
  logic [7:0]  m_attempts;
  logic [15:0] m_backoff;
  logic        m_saw;
  logic [31:0] m_raced;

  result_t   awaited_results[$];
  plan_row_t plan[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        cycle_count = 0;
  bit        no_idle = 1'b0;
  bit        hold_request = 1'b0;

  function automatic logic [31:0] request_word_of(logic [31:0] addr);
    return (addr & CHAN_MASK) | CHAN_NUM;
  endfunction

  function automatic void start_attempt();
    m_phase    = PH_SPACE;
    m_spin_cnt = m_spin;
    m_saw      = 1'b0;
    m_raced    = 32'd0;
  endfunction

  function automatic void close_attempt(outcome_e oc, inout result_t r);
    logic [7:0] lim;
    lim = (m_retries == 8'd0) ? 8'd1 : m_retries;
    if (oc == OC_OK || m_attempts != 8'd255) m_attempts = m_attempts + 8'd1;
    if (oc == OC_OK || m_attempts >= lim) begin
      r.finished     = 1'b1;
      r.outcome      = oc;
      r.foreign_word = m_raced;
      m_phase        = PH_IDLE;
    end else if (m_delay == 16'd0) begin
      start_attempt();
    end else begin
      m_phase   = PH_BACKOFF;
      m_backoff = m_delay;
    end
  endfunction

  function automatic result_t next_mailbox_result(poll_item_t it);
    result_t r;
    logic    matched;
    r = '0;
    matched = 1'b0;
    if (it.opcode == OP_START) begin
      // A start is ignored unless the sequencer is idle.
      if (m_phase == PH_IDLE) begin
        m_attempts = 8'd0;
        m_backoff  = 16'd0;
        start_attempt();
      end
    end else begin
      case (m_phase)
        PH_SPACE: begin
          if (!it.write_full) begin
            r.post_strobe = 1'b1;
            r.post_word   = request_word_of(m_buf);
            m_phase       = PH_DRAIN;
            m_spin_cnt    = m_spin;
            if (m_spin_cnt == 32'd0) close_attempt(OC_EMPTY, r);
          end else if (m_spin_cnt == 32'd0) begin
            close_attempt(OC_WRFULL, r);
          end else begin
            m_spin_cnt = m_spin_cnt - 32'd1;
          end
        end
        PH_DRAIN: begin
          if (m_spin_cnt == 32'd0) begin
            close_attempt(m_saw ? OC_RACED : OC_EMPTY, r);
          end else begin
            if (!it.read_empty) begin
              r.pop_strobe = 1'b1;
              m_saw = 1'b1;
              if (it.head_word == request_word_of(m_buf)) matched = 1'b1;
              else m_raced = it.head_word;
            end
            if (matched) begin
              close_attempt((it.response_code == RESP_OK) ? OC_OK : OC_BADRESP, r);
            end else begin
              m_spin_cnt = m_spin_cnt - 32'd1;
              if (m_spin_cnt == 32'd0) close_attempt(m_saw ? OC_RACED : OC_EMPTY, r);
            end
          end
        end
        PH_BACKOFF: begin
          if (m_backoff != 16'd0) m_backoff = m_backoff - 16'd1;
          if (m_backoff == 16'd0) start_attempt();
        end
        default: ;
      endcase
    end
    r.busy_res = (m_phase != PH_IDLE);
    return r;
  endfunction

  // Random item shaped by where the sequencer should be, so most transactions
  // run to a real outcome; a small share is plain noise.
  function automatic poll_item_t pick_poll();
    poll_item_t  it;
    logic [31:0] req;
    int          pick;
    req = request_word_of(m_buf);
    it.opcode        = OP_POLL;
    it.write_full    = ($urandom_range(0, 3) == 0);
    it.read_empty    = ($urandom_range(0, 2) == 0);
    it.response_code = ($urandom_range(0, 3) == 0) ? $urandom : RESP_OK;
    pick = $urandom_range(0, 9);
    if (pick < 5) it.head_word = req;
    else if (pick < 8) it.head_word = $urandom;
    else it.head_word = req ^ (32'd1 << $urandom_range(0, 31));
    if ($urandom_range(0, 19) == 0) begin
      it.opcode     = 1'($urandom_range(0, 1));
      it.write_full = 1'($urandom_range(0, 1));
      it.read_empty = 1'($urandom_range(0, 1));
      it.head_word  = $urandom;
    end else if (m_phase == PH_IDLE) begin
      if ($urandom_range(0, 9) != 0) it.opcode = OP_START;
    end else if ($urandom_range(0, 29) == 0) begin
      it.opcode = OP_START;
    end
    return it;
  endfunction

  function automatic void row_cfg(cfg_idx_e idx, logic [31:0] data);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    row.item   = '0;
    row.known  = 1'b0;
    row.want   = '0;
    plan.push_back(row);
  endfunction

  function automatic void row_item(logic op, logic wf, logic re, logic [31:0] head,
                                   logic [31:0] resp);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.idx    = CFG_BUFFER_ADDRESS;
    row.data   = 32'd0;
    row.known  = 1'b0;
    row.want   = '0;
    row.item = '{opcode: op, write_full: wf, read_empty: re, head_word: head,
                 response_code: resp};
    plan.push_back(row);
  endfunction

  function automatic void row_known(logic post, logic [31:0] word, logic pop, logic fin,
                                    outcome_e oc, logic [31:0] foreign, logic busy);
    plan[plan.size() - 1].known = 1'b1;
    plan[plan.size() - 1].want  = '{post_strobe: post, post_word: word, pop_strobe: pop,
                                    finished: fin, outcome: oc, foreign_word: foreign,
                                    busy_res: busy};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("MISMATCH result %0d %s: got %h want %h", results_seen, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Offers one item, waits for it to be taken and records what it should cause.
  // Returns at the accepting rising edge.
  task automatic send_item(input poll_item_t it, input bit known, input result_t want);
    result_t predicted;
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < 32) begin
      in_chan.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_chan.valid         <= 1'b1;
    in_chan.opcode        <= it.opcode;
    in_chan.write_full    <= it.write_full;
    in_chan.read_empty    <= it.read_empty;
    in_chan.head_word     <= it.head_word;
    in_chan.response_code <= it.response_code;
    do @(posedge clk_i); while (!in_chan.ready);
    predicted = next_mailbox_result(it);
    awaited_results.push_back(known ? want : predicted);
  endtask

  // Lets the block drain completely before a register write.
  task automatic settle();
    @(negedge clk_i);
    in_chan.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BUFFER_ADDRESS: m_buf     = data;
      CFG_SPIN_LIMIT:     m_spin    = data;
      CFG_RETRY_LIMIT:    m_retries = data[7:0];
      CFG_RETRY_DELAY:    m_delay   = data[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [31:0] addr, input logic [31:0] spin,
                               input logic [7:0] lim, input logic [15:0] delay);
    settle();
    write_register(CFG_BUFFER_ADDRESS, addr);
    write_register(CFG_SPIN_LIMIT, spin);
    write_register(CFG_RETRY_LIMIT, {24'd0, lim});
    write_register(CFG_RETRY_DELAY, {16'd0, delay});
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch("item with nothing awaited", {31'd0, out_chan.finished}, 32'd0);
      end else begin
        want = awaited_results.pop_front();
        check_field("post_strobe", {31'd0, out_chan.post_strobe}, {31'd0, want.post_strobe});
        check_field("post_word", out_chan.post_word, want.post_word);
        check_field("pop_strobe", {31'd0, out_chan.pop_strobe}, {31'd0, want.pop_strobe});
        check_field("finished", {31'd0, out_chan.finished}, {31'd0, want.finished});
        check_field("outcome", {29'd0, out_chan.outcome}, {29'd0, want.outcome});
        check_field("foreign_word", out_chan.foreign_word, want.foreign_word);
        check_field("busy_res", {31'd0, out_chan.busy_res}, {31'd0, want.busy_res});
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off while items keep coming.
  initial begin : result_sink
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= (no_idle || $urandom_range(0, 99) >= 32);
      end
    end
  end

  initial begin
    int          sent;
    logic [31:0] addr;
    logic [31:0] spin;
    logic [7:0]  lim;
    logic [15:0] delay;

    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_index_i           = CFG_BUFFER_ADDRESS;
    cfg_wdata_i           = 32'd0;
    in_chan.valid         = 1'b0;
    in_chan.opcode        = OP_POLL;
    in_chan.write_full    = 1'b0;
    in_chan.read_empty    = 1'b1;
    in_chan.head_word     = 32'd0;
    in_chan.response_code = 32'd0;

    m_buf      = 32'd0;
    m_spin     = SPIN_LIMIT_RST;
    m_retries  = RETRY_LIMIT_RST;
    m_delay    = RETRY_DELAY_RST;
    m_phase    = PH_IDLE;
    m_spin_cnt = 32'd0;
    m_attempts = 8'd0;
    m_backoff  = 16'd0;
    m_saw      = 1'b0;
    m_raced    = 32'd0;
    sent       = 0;

    // Reset defaults: a poll while idle, a start while busy, a foreign word
    // before the own word comes back.
    row_item(OP_POLL, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    row_known(1'b0, 32'd0, 1'b0, 1'b0, OC_OK, 32'd0, 1'b0);
    row_item(OP_START, 1'b0, 1'b0, 32'd0, 32'd0);
    row_known(1'b0, 32'd0, 1'b0, 1'b0, OC_OK, 32'd0, 1'b1);
    row_item(OP_START, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    row_known(1'b0, 32'd0, 1'b0, 1'b0, OC_OK, 32'd0, 1'b1);
    row_item(OP_POLL, 1'b1, 1'b1, 32'd0, 32'd0);
    row_item(OP_POLL, 1'b0, 1'b0, 32'h8, 32'd0);
    row_known(1'b1, 32'h8, 1'b0, 1'b0, OC_OK, 32'd0, 1'b1);
    row_item(OP_POLL, 1'b0, 1'b0, 32'hFFFF_FFFF, RESP_OK);
    row_item(OP_POLL, 1'b1, 1'b0, 32'h8, RESP_OK);
    row_known(1'b0, 32'd0, 1'b1, 1'b1, OC_OK, 32'hFFFF_FFFF, 1'b0);
    // Zero spin limit and a retry limit of zero: no reply on the posting tick.
    row_cfg(CFG_BUFFER_ADDRESS, 32'hFFFF_FFFF);
    row_cfg(CFG_SPIN_LIMIT, 32'd0);
    row_cfg(CFG_RETRY_LIMIT, 32'd0);
    row_cfg(CFG_RETRY_DELAY, 32'd0);
    row_item(OP_START, 1'b0, 1'b0, 32'd0, 32'd0);
    row_item(OP_POLL, 1'b0, 1'b1, 32'd0, 32'd0);
    row_known(1'b1, 32'hFFFF_FFF8, 1'b0, 1'b1, OC_EMPTY, 32'd0, 1'b0);
    // Write full on the first attempt, retried at once, then raced.
    row_cfg(CFG_SPIN_LIMIT, 32'd1);
    row_cfg(CFG_RETRY_LIMIT, 32'd2);
    row_item(OP_START, 1'b0, 1'b0, 32'd0, 32'd0);
    row_item(OP_POLL, 1'b1, 1'b1, 32'd0, 32'd0);
    row_item(OP_POLL, 1'b1, 1'b1, 32'd0, 32'd0);
    row_item(OP_POLL, 1'b0, 1'b1, 32'd0, 32'd0);
    row_item(OP_POLL, 1'b0, 1'b0, 32'h1234_5678, RESP_OK);
    row_known(1'b0, 32'd0, 1'b1, 1'b1, OC_RACED, 32'h1234_5678, 1'b0);
    // Nothing arrives before the spin count runs out.
    row_cfg(CFG_SPIN_LIMIT, 32'd2);
    row_cfg(CFG_RETRY_LIMIT, 32'd1);
    row_item(OP_START, 1'b0, 1'b0, 32'd0, 32'd0);
    row_item(OP_POLL, 1'b0, 1'b1, 32'd0, 32'd0);
    row_item(OP_POLL, 1'b0, 1'b1, 32'd0, 32'd0);
    row_item(OP_POLL, 1'b0, 1'b1, 32'd0, 32'd0);
    row_known(1'b0, 32'd0, 1'b0, 1'b1, OC_EMPTY, 32'd0, 1'b0);
    // Bad response, a backoff of three ticks, then success.
    row_cfg(CFG_SPIN_LIMIT, 32'hFFFF_FFFF);
    row_cfg(CFG_RETRY_LIMIT, 32'd2);
    row_cfg(CFG_RETRY_DELAY, 32'd3);
    row_item(OP_START, 1'b0, 1'b0, 32'd0, 32'd0);
    row_item(OP_POLL, 1'b0, 1'b1, 32'd0, 32'd0);
    row_item(OP_POLL, 1'b0, 1'b0, 32'hFFFF_FFF8, 32'd0);
    row_item(OP_POLL, 1'b1, 1'b0, 32'hFFFF_FFF8, RESP_OK);
    row_item(OP_POLL, 1'b0, 1'b0, 32'hFFFF_FFF8, RESP_OK);
    row_item(OP_POLL, 1'b1, 1'b1, 32'hFFFF_FFF8, RESP_OK);
    row_item(OP_POLL, 1'b0, 1'b1, 32'd0, 32'd0);
    row_item(OP_POLL, 1'b0, 1'b0, 32'hFFFF_FFF8, RESP_OK);
    row_known(1'b0, 32'd0, 1'b1, 1'b1, OC_OK, 32'd0, 1'b0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        settle();
        write_register(plan[k].idx, plan[k].data);
      end else begin
        send_item(plan[k].item, plan[k].known, plan[k].want);
      end
    end

    for (int p = 0; p < 6; p++) begin
      addr  = $urandom;
      spin  = 32'($urandom_range(1, 4));
      lim   = 8'($urandom_range(1, 5));
      delay = 16'($urandom_range(0, 4));
      case (p)
        0: begin spin = 32'd3; lim = 8'd3; delay = 16'd2; end
        1: begin addr = 32'd0; spin = 32'd0; lim = 8'd255; delay = 16'd0; end
        2: begin addr = 32'hFFFF_FFFF; spin = 32'hFFFF_FFFF; lim = 8'd1; delay = 16'hFFFF; end
        5: begin spin = 32'd1; lim = 8'd8; delay = 16'd1; end
        default: ;
      endcase
      apply_setting(addr, spin, lim, delay);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sent++;
        no_idle = (sent >= 100 && sent < 160);
        if (sent == 40) hold_request = 1'b1;
        send_item(pick_poll(), 1'b0, '0);
      end
      // Run the open transaction to its end so the next setting starts idle.
      while (m_phase != PH_IDLE) send_item(pick_poll(), 1'b0, '0);
    end

    @(negedge clk_i);
    in_chan.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
